// File: hw/rtl/lzrd_pkg.sv
// Shared constants for the LZSS ring-window decompressor.
package lzrd_pkg;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned RING_AW      = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W       = RING_AW + 1;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned FLAG_W       = BYTE_W + 1;
  localparam int unsigned LEN_FIELD_W  = 4;
  localparam int unsigned LEN_W        = 5;

  localparam logic [RING_AW-1:0] START_POS = RING_AW'(12'hFEE);
  localparam logic [LEN_W-1:0]   LEN_BIAS  = LEN_W'(3);
  localparam logic [FLAG_W-1:0]  FLAG_IDLE = FLAG_W'(1);
  localparam logic [FLAG_W-1:0]  FLAG_GUARD = FLAG_W'(9'h100);

endpackage

// File: hw/rtl/lzrd_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module lzrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lzss_ring_decompressor_top.sv
// Top level of the LZSS decompressor with a 4096-byte ring window.
//
// Takes compressed bytes on the slave stream, one word per byte, and gives
// decompressed bytes on the master stream. A flag byte or the low byte of a
// match gives no output; a literal gives one word. The high byte of a match
// ties up the block until its copy is done: the copy runs through the single
// read port of the ring RAM, one byte per cycle while the sink is ready, each
// byte written back at the write pointer as it leaves the data return stage.
// A byte read in the same cycle as it is written is forwarded. There is no
// clearing pass: a fill count of bytes written since reset or end of stream
// tells which ring entries are live, and any other entry reads as zero, so
// the block is ready straight after reset and after a word with tlast. tlast
// on output marks the last byte caused by one input word. A stalled sink
// holds the output word and stops input; the copy pauses without loss.
module lzss_ring_decompressor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  localparam int unsigned AW = lzrd_pkg::RING_AW;
  localparam int unsigned BW = lzrd_pkg::BYTE_W;

  typedef enum logic {
    PH_BASE,
    PH_MATCH_HI
  } phase_e;

  // parser state
  phase_e                          phase_q;
  logic [lzrd_pkg::FLAG_W-1:0]     flags_q;
  logic [BW-1:0]                   held_q;
  // ring write side
  logic [AW-1:0]                   wpos_q;
  logic [lzrd_pkg::FILL_W-1:0]     fill_q;
  // copy engine: read issue stage
  logic [AW-1:0]                   rpos_q;
  logic [lzrd_pkg::LEN_W-1:0]      rem_q;
  logic                            eos_pend_q;
  // copy engine: data return stage
  logic                            s2_vld_q;
  logic                            s2_fwd_q;
  logic                            s2_zero_q;
  logic                            s2_last_q;
  logic [BW-1:0]                   s2_fdata_q;
  // output register
  logic                            out_vld_q;
  logic [BW-1:0]                   out_data_q;
  logic                            out_last_q;

  logic          out_ready, busy, in_acc;
  logic          is_flag, is_lit, is_low, is_hi;
  logic          lit_wr, s2_adv, issue, run_done, clr_now;
  logic          rd_fwd, rd_zero;
  logic [AW-1:0] rd_dist;
  logic [BW-1:0] copy_byte, ram_rdata, ram_wdata;
  logic          ram_we;
  logic [lzrd_pkg::LEN_W-1:0] match_len;

  assign out_ready       = !out_vld_q || m_axis_tready_i;
  assign busy            = (rem_q != '0) || s2_vld_q;
  assign s_axis_tready_o = !busy && out_ready;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // decode of the incoming word against parser state; an empty flag
  // register (guard bit only, or zero) means a flag byte is due
  assign is_hi   = (phase_q == PH_MATCH_HI);
  assign is_flag = !is_hi && (flags_q <= lzrd_pkg::FLAG_IDLE);
  assign is_lit  = !is_hi && !is_flag && flags_q[0];
  assign is_low  = !is_hi && !is_flag && !flags_q[0];

  assign match_len = lzrd_pkg::LEN_W'(s_axis_tdata_i[lzrd_pkg::LEN_FIELD_W-1:0])
                     + lzrd_pkg::LEN_BIAS;

  assign lit_wr   = in_acc && is_lit;
  assign s2_adv   = s2_vld_q && out_ready;
  assign issue    = (rem_q != '0) && (!s2_vld_q || s2_adv);
  assign run_done = s2_adv && s2_last_q;

  // end of stream: immediate for anything but a match, else after the copy
  assign clr_now = (in_acc && s_axis_tlast_i && !is_hi) || (run_done && eos_pend_q);

  // byte leaving the return stage: forwarded, never-written (zero) or RAM
  assign copy_byte = s2_fwd_q ? s2_fdata_q : (s2_zero_q ? '0 : ram_rdata);

  assign ram_we    = lit_wr || s2_adv;
  assign ram_wdata = lit_wr ? s_axis_tdata_i : copy_byte;

  // read hits the entry written this very cycle
  assign rd_fwd  = s2_adv && (rpos_q == wpos_q);
  // live entries run from START_POS for fill_q bytes, with wrap
  assign rd_dist = rpos_q - lzrd_pkg::START_POS;
  assign rd_zero = ({1'b0, rd_dist} >= fill_q);

  lzrd_ram #(
    .WIDTH (BW),
    .DEPTH (lzrd_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (rpos_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_BASE;
      flags_q    <= lzrd_pkg::FLAG_IDLE;
      wpos_q     <= lzrd_pkg::START_POS;
      fill_q     <= '0;
      rem_q      <= '0;
      eos_pend_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      // parser
      if (in_acc) begin
        if (s_axis_tlast_i) begin
          phase_q <= PH_BASE;
          flags_q <= lzrd_pkg::FLAG_IDLE;
        end else if (is_hi) begin
          phase_q <= PH_BASE;
          flags_q <= flags_q >> 1;
        end else if (is_flag) begin
          flags_q <= lzrd_pkg::FLAG_GUARD | lzrd_pkg::FLAG_W'(s_axis_tdata_i);
        end else if (is_lit) begin
          flags_q <= flags_q >> 1;
        end else begin
          phase_q <= PH_MATCH_HI;
        end
      end

      // ring write pointer and fill count
      if (clr_now) begin
        wpos_q <= lzrd_pkg::START_POS;
        fill_q <= '0;
      end else if (ram_we) begin
        wpos_q <= wpos_q + 1'b1;
        if (fill_q != lzrd_pkg::FILL_W'(lzrd_pkg::WINDOW_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end

      // copy engine
      if (in_acc && is_hi) begin
        rem_q      <= match_len;
        eos_pend_q <= s_axis_tlast_i;
      end else begin
        if (issue) begin
          rem_q <= rem_q - 1'b1;
        end
        if (run_done) begin
          eos_pend_q <= 1'b0;
        end
      end

      if (issue) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end

      if (lit_wr || s2_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      if (lit_wr) begin
        out_data_q <= s_axis_tdata_i;
        out_last_q <= 1'b1;
      end else if (s2_adv) begin
        out_data_q <= copy_byte;
        out_last_q <= s2_last_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && is_low) begin
      held_q <= s_axis_tdata_i;
    end

    if (in_acc && is_hi) begin
      rpos_q <= {s_axis_tdata_i[BW-1:lzrd_pkg::LEN_FIELD_W], held_q};
    end else if (issue) begin
      rpos_q <= rpos_q + 1'b1;
    end

    if (issue) begin
      s2_fwd_q   <= rd_fwd;
      s2_zero_q  <= rd_zero;
      s2_last_q  <= (rem_q == lzrd_pkg::LEN_W'(1));
      s2_fdata_q <= copy_byte;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: hw/rtl/lzrd_checker.sv
// Port-level checks for the LZSS decompressor, bound to the top level.
module lzrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // no input taken while the output register is blocked
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready while output stalled");

  // a run is never interrupted by new input
  a_run_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready in the middle of a run");

  // copy pipeline keeps the output fed within a run
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("bubble inside an output run");

endmodule

bind lzss_ring_decompressor_top lzrd_checker u_lzrd_checker (.*);
